@@ hdl/sps_pkg.sv @@
// Package for the stepper phase sequencer core.
// It holds the register addresses, the drive mode codes and the coil pattern tables.
// It depends on nothing else.
package sps_pkg;

	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 32;
	localparam int unsigned StepWidth = 16;
	localparam int unsigned RateWidth = 15;
	localparam int unsigned CountWidth = 16;

	localparam logic [CountWidth-1:0] StoppedCount = 16'd65534;
	localparam logic [RateWidth-1:0] RateReset = 15'd100;

	typedef enum logic [1:0] {
		REG_DRIVE_MODE = 2'd0,
		REG_HOLD_AT_STOP = 2'd1,
		REG_RATE_DIVIDER = 2'd2,
		REG_UNUSED = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		MODE_SINGLE = 2'd0,
		MODE_HALF = 2'd1,
		MODE_TWO = 2'd2,
		MODE_SPARE = 2'd3
	} drive_mode_t;

	typedef enum logic {
		ACT_TICK = 1'b0,
		ACT_LOAD = 1'b1
	} action_t;

	function automatic logic [3:0] coil_pattern(input drive_mode_t mode, input logic [2:0] ph);
		logic [3:0] pat;
		pat = 4'h0;
		unique case (mode)
			MODE_SINGLE: begin
				case (ph[1:0])
					2'd0: pat = 4'h1;
					2'd1: pat = 4'h2;
					2'd2: pat = 4'h4;
					default: pat = 4'h8;
				endcase
			end
			MODE_HALF: begin
				case (ph)
					3'd0: pat = 4'h1;
					3'd1: pat = 4'h3;
					3'd2: pat = 4'h2;
					3'd3: pat = 4'h6;
					3'd4: pat = 4'h4;
					3'd5: pat = 4'hC;
					3'd6: pat = 4'h8;
					default: pat = 4'h9;
				endcase
			end
			default: begin
				case (ph[1:0])
					2'd0: pat = 4'h3;
					2'd1: pat = 4'h6;
					2'd2: pat = 4'hC;
					default: pat = 4'h9;
				endcase
			end
		endcase
		return pat;
	endfunction

endpackage

@@ hdl/stepper_phase_sequencer_core.sv @@
// Stepper phase sequencer core: input register, commutation logic and result registers.
// It depends on sps_pkg for the register map, the drive modes and the coil tables.
//
// Usage: each item on the input channel is either a tick of the commutation clock
// (action 0) or a load of a signed step count (action 1, step_request). Every item
// gives exactly one result: the coil pattern and the remaining step count after it.
// Items are taken into an input register and processed in a single pass as they move
// into the result registers, which also hold the sequencer state.
// An accepted item waits in the input register and moves into the result registers
// when they are free, where its result is shown; one item is accepted in every cycle
// while results are taken. The state update of one item must finish before the next,
// which sets the loop from the result registers back through the commutation logic.
// When the receiver stalls, the result holds, the input register fills and then
// item_stall is raised until the result is taken. Reset clears the state: coils off,
// no steps pending, drive mode 0, hold off and a rate divider of 100. The user must
// write configuration through the APB port while idle; the block does not enforce it.
module stepper_phase_sequencer_core
	import sps_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        action,
	input  logic signed [StepWidth-1:0] step_request,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [3:0]                  coil_drive,
	output logic signed [StepWidth-1:0] remaining_steps,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [AddrWidth-1:0]        paddr,
	input  logic [DataWidth-1:0]        pwdata,
	output logic [DataWidth-1:0]        prdata,
	output logic                        pready
);

	drive_mode_t                 mode_q;
	logic                        hold_q;
	logic [RateWidth-1:0]        rate_q;

	logic                        valid_s1;
	action_t                     act_s1;
	logic signed [StepWidth-1:0] step_s1;

	logic                        out_valid_q;
	logic [3:0]                  coil_q;
	logic signed [StepWidth-1:0] rem_q;
	logic                        prev_nz_q;
	logic [2:0]                  phase_q;
	logic [CountWidth-1:0]       count_q;

	logic                        advance;
	logic                        cfg_write;
	reg_index_t                  cfg_idx;

	logic [3:0]                  coil_d;
	logic signed [StepWidth-1:0] rem_d;
	logic                        prev_nz_d;
	logic [2:0]                  phase_d;
	logic [CountWidth-1:0]       count_d;
	logic [CountWidth-1:0]       count_inc;
	logic signed [StepWidth-1:0] rem_step;
	logic [2:0]                  phase_inc;

	assign pready = 1'b1;
	assign cfg_idx = reg_index_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_DRIVE_MODE: prdata = {{(DataWidth-2){1'b0}}, mode_q};
			REG_HOLD_AT_STOP: prdata = {{(DataWidth-1){1'b0}}, hold_q};
			REG_RATE_DIVIDER: prdata = {{(DataWidth-RateWidth){1'b0}}, rate_q};
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SINGLE;
			hold_q <= 1'b0;
			rate_q <= RateReset;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_DRIVE_MODE: mode_q <= drive_mode_t'(pwdata[1:0]);
				REG_HOLD_AT_STOP: hold_q <= pwdata[0];
				REG_RATE_DIVIDER: rate_q <= pwdata[RateWidth-1:0];
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign result_valid = out_valid_q;
	assign coil_drive = coil_q;
	assign remaining_steps = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			act_s1 <= action_t'(action);
			step_s1 <= step_request;
		end
	end

	always_comb begin
		coil_d = coil_q;
		rem_d = rem_q;
		prev_nz_d = prev_nz_q;
		phase_d = phase_q;
		count_d = count_q;
		count_inc = count_q + 1'b1;
		rem_step = rem_q;
		phase_inc = phase_q;
		if (act_s1 == ACT_LOAD) begin
			rem_d = step_s1;
			if (step_s1 == '0 && !hold_q) begin
				coil_d = 4'h0;
			end
		end else if (rem_q == '0) begin
			count_d = StoppedCount;
			prev_nz_d = 1'b0;
		end else if (count_inc < {1'b0, rate_q}) begin
			count_d = count_inc;
		end else begin
			count_d = '0;
			if (prev_nz_q) begin
				rem_step = rem_q[StepWidth-1] ? rem_q + 16'sd1 : rem_q - 16'sd1;
			end
			rem_d = rem_step;
			prev_nz_d = (rem_step != '0);
			if (rem_step == '0) begin
				if (!hold_q) begin
					coil_d = 4'h0;
				end
			end else begin
				phase_inc = rem_q[StepWidth-1] ? phase_q - 3'd1 : phase_q + 3'd1;
				phase_d = (mode_q == MODE_HALF) ? phase_inc : {1'b0, phase_inc[1:0]};
				coil_d = coil_pattern(mode_q, phase_d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			coil_q <= 4'h0;
			rem_q <= '0;
			prev_nz_q <= 1'b0;
			phase_q <= 3'd0;
			count_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				coil_q <= coil_d;
				rem_q <= rem_d;
				prev_nz_q <= prev_nz_d;
				phase_q <= phase_d;
				count_q <= count_d;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_load_takes_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && act_s1 == ACT_LOAD |=> rem_q == $past(step_s1))
		else $error("loaded step count not taken");

	a_stopped_preset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && act_s1 == ACT_TICK && rem_q == '0 |=> count_q == StoppedCount)
		else $error("divider not preset while stopped");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !item_stall)
		else $error("stall raised with empty input register");
`endif

endmodule
